FILE: rtl/core/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

   // hue scale: 1/64 degree steps
   localparam logic [14:0] HUE_SECTOR = 15'd3840;
   localparam logic [14:0] HUE_FULL   = 15'd23040;

   // divide by 15 as multiply by ceil(2^24 / 15) and shift, exact for 20-bit values
   localparam int          RECIP_SHIFT = 24;
   localparam logic [20:0] RECIP15     = 21'd1118482;

   typedef enum logic [2:0] {
      SECT_0 = 3'd0,
      SECT_1 = 3'd1,
      SECT_2 = 3'd2,
      SECT_3 = 3'd3,
      SECT_4 = 3'd4,
      SECT_5 = 3'd5
   } sector_type;

   typedef struct packed {
      logic [14:0] hue;
      logic [15:0] saturation;
      logic [15:0] lightness;
   } req_type;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        in_range;
   } rsp_type;

   // after range check and sector split
   typedef struct packed {
      logic        in_range;
      sector_type  sector;
      logic [11:0] xfac;
      logic [15:0] sat;
      logic [15:0] lit;
   } front_type;

   // after chroma and hue-weight product
   typedef struct packed {
      logic        in_range;
      sector_type  sector;
      logic [19:0] quot;
      logic [15:0] chroma;
      logic [15:0] base;
   } chroma_type;

endpackage

FILE: rtl/core/hsl2rgb_front.sv
module hsl2rgb_front #(
   parameter int COMPONENT_FRAC_BITS = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  hsl2rgb_pkg::req_type up_data,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output hsl2rgb_pkg::front_type dn_data
);
   import hsl2rgb_pkg::*;

   localparam int AW = (COMPONENT_FRAC_BITS + 2 > 18) ? COMPONENT_FRAC_BITS + 2 : 18;
   localparam logic [AW-1:0] ONE_W = AW'(1) << COMPONENT_FRAC_BITS;

   logic        vld_ff;
   front_type   data_ff;
   front_type   data_in;
   sector_type  sector;
   logic [14:0] sector_base;
   logic [14:0] offset;

   // sector from threshold compares
   always_comb begin
      priority if (up_data.hue < 15'd3840) begin
         sector      = SECT_0;
         sector_base = 15'd0;
      end else if (up_data.hue < 15'd7680) begin
         sector      = SECT_1;
         sector_base = HUE_SECTOR;
      end else if (up_data.hue < 15'd11520) begin
         sector      = SECT_2;
         sector_base = 15'd7680;
      end else if (up_data.hue < 15'd15360) begin
         sector      = SECT_3;
         sector_base = 15'd11520;
      end else if (up_data.hue < 15'd19200) begin
         sector      = SECT_4;
         sector_base = 15'd15360;
      end else begin
         sector      = SECT_5;
         sector_base = 15'd19200;
      end
   end

   assign offset = up_data.hue - sector_base;

   // range check and hue weight (triangle over two sectors)
   always_comb begin
      data_in.in_range = (up_data.hue < HUE_FULL) &&
                         (AW'(up_data.saturation) <= ONE_W) &&
                         (AW'(up_data.lightness) <= ONE_W);
      data_in.sector   = sector;
      data_in.xfac     = sector[0] ? 12'(HUE_SECTOR - offset) : offset[11:0];
      data_in.sat      = up_data.saturation;
      data_in.lit      = up_data.lightness;
   end

   assign up_ready = !vld_ff || dn_ready;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

endmodule

FILE: rtl/core/hsl2rgb_chroma.sv
module hsl2rgb_chroma #(
   parameter int COMPONENT_FRAC_BITS = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  hsl2rgb_pkg::front_type  up_data,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output hsl2rgb_pkg::chroma_type dn_data
);
   import hsl2rgb_pkg::*;

   localparam int F  = COMPONENT_FRAC_BITS;
   localparam int AW = (F + 2 > 18) ? F + 2 : 18;
   localparam logic [AW-1:0] ONE_W = AW'(1) << F;

   typedef struct packed {
      logic        in_range;
      sector_type  sector;
      logic [11:0] xfac;
      logic [15:0] chroma;
      logic [15:0] lit;
   } mid_type;

   logic          s1_vld_ff;
   mid_type       s1_ff;
   mid_type       s1_in;
   logic          s1_ready;
   logic          s2_vld_ff;
   chroma_type    s2_ff;
   chroma_type    s2_in;
   logic [AW-1:0] lit2;
   logic [AW-1:0] ldiff;
   logic [AW-1:0] lfac;
   logic [F+16:0] chroma_prod;
   logic [27:0]   hue_prod;

   // chroma = S * (1 - |2L - 1|)
   always_comb begin
      lit2        = AW'({up_data.lit, 1'b0});
      ldiff       = (lit2 >= ONE_W) ? (lit2 - ONE_W) : (ONE_W - lit2);
      lfac        = ONE_W - ldiff;
      chroma_prod = (F+17)'(up_data.sat) * (F+17)'(lfac[F:0]);
      s1_in.in_range = up_data.in_range;
      s1_in.sector   = up_data.sector;
      s1_in.xfac     = up_data.xfac;
      s1_in.chroma   = chroma_prod[F +: 16];
      s1_in.lit      = up_data.lit;
   end

   // chroma times hue weight, pre-shifted by 256; base level m = L - C/2
   always_comb begin
      hue_prod       = 28'(s1_ff.chroma) * 28'(s1_ff.xfac);
      s2_in.in_range = s1_ff.in_range;
      s2_in.sector   = s1_ff.sector;
      s2_in.quot     = hue_prod[27:8];
      s2_in.chroma   = s1_ff.chroma;
      s2_in.base     = s1_ff.lit - {1'b0, s1_ff.chroma[15:1]};
   end

   assign up_ready = !s1_vld_ff || s1_ready;
   assign s1_ready = !s2_vld_ff || dn_ready;

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (up_ready) begin
            s1_vld_ff <= up_valid;
         end
         if (s1_ready) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         s1_ff <= s1_in;
      end
      if (s1_ready && s1_vld_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign dn_valid = s2_vld_ff;
   assign dn_data  = s2_ff;

endmodule

FILE: rtl/core/hsl2rgb_mix.sv
module hsl2rgb_mix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  hsl2rgb_pkg::chroma_type up_data,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output hsl2rgb_pkg::rsp_type    dn_data
);
   import hsl2rgb_pkg::*;

   typedef struct packed {
      logic        in_range;
      sector_type  sector;
      logic [15:0] xval;
      logic [15:0] chroma;
      logic [15:0] base;
   } xval_type;

   logic        s1_vld_ff;
   xval_type    s1_ff;
   xval_type    s1_in;
   logic        s1_ready;
   logic        s2_vld_ff;
   rsp_type     s2_ff;
   rsp_type     s2_in;
   logic [40:0] recip_prod;
   logic [15:0] cm;
   logic [15:0] xm;

   // finish divide by 3840: divide by 15 through reciprocal
   always_comb begin
      recip_prod     = 41'(up_data.quot) * 41'(RECIP15);
      s1_in.in_range = up_data.in_range;
      s1_in.sector   = up_data.sector;
      s1_in.xval     = recip_prod[RECIP_SHIFT +: 16];
      s1_in.chroma   = up_data.chroma;
      s1_in.base     = up_data.base;
   end

   // place C+m, X+m and m by sector, black when out of range
   always_comb begin
      cm = s1_ff.chroma + s1_ff.base;
      xm = s1_ff.xval + s1_ff.base;
      unique case (s1_ff.sector)
         SECT_0: begin
            s2_in.red = cm;          s2_in.green = xm;          s2_in.blue = s1_ff.base;
         end
         SECT_1: begin
            s2_in.red = xm;          s2_in.green = cm;          s2_in.blue = s1_ff.base;
         end
         SECT_2: begin
            s2_in.red = s1_ff.base;  s2_in.green = cm;          s2_in.blue = xm;
         end
         SECT_3: begin
            s2_in.red = s1_ff.base;  s2_in.green = xm;          s2_in.blue = cm;
         end
         SECT_4: begin
            s2_in.red = xm;          s2_in.green = s1_ff.base;  s2_in.blue = cm;
         end
         default: begin
            s2_in.red = cm;          s2_in.green = s1_ff.base;  s2_in.blue = xm;
         end
      endcase
      s2_in.in_range = s1_ff.in_range;
      if (!s1_ff.in_range) begin
         s2_in.red   = '0;
         s2_in.green = '0;
         s2_in.blue  = '0;
      end
   end

   assign up_ready = !s1_vld_ff || s1_ready;
   assign s1_ready = !s2_vld_ff || dn_ready;

   // stage registers, the last one is the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (up_ready) begin
            s1_vld_ff <= up_valid;
         end
         if (s1_ready) begin
            s2_vld_ff <= s1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         s1_ff <= s1_in;
      end
      if (s1_ready && s1_vld_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign dn_valid = s2_vld_ff;
   assign dn_data  = s2_ff;

endmodule

FILE: rtl/core/hsl_to_rgb_converter.sv
// hsl to rgb colour conversion, five register stages
// a request is registered in the front stage, then in the chroma stages, then in the mix stages
// throughput: one colour per cycle; each stage holds while its successor is full and stalled
// the stages are cut around the chroma multiplier, the hue-weight multiplier and the reciprocal divide
// reset: synchronous, active high, clears every stage valid bit; no payload is reset
module hsl_to_rgb_converter #(
   parameter int COMPONENT_FRAC_BITS = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hsl2rgb_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output hsl2rgb_pkg::rsp_type rsp_data
);
   import hsl2rgb_pkg::*;

   logic       front_valid;
   logic       front_ready;
   front_type  front_data;
   logic       chroma_valid;
   logic       chroma_ready;
   chroma_type chroma_data;

   // range check and sector split
   hsl2rgb_front #(
      .COMPONENT_FRAC_BITS(COMPONENT_FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .up_valid(req_valid),
      .up_ready(req_ready),
      .up_data (req_data),
      .dn_valid(front_valid),
      .dn_ready(front_ready),
      .dn_data (front_data)
   );

   // chroma and hue-weight products
   hsl2rgb_chroma #(
      .COMPONENT_FRAC_BITS(COMPONENT_FRAC_BITS)
   ) u_chroma (
      .clock   (clock),
      .reset   (reset),
      .up_valid(front_valid),
      .up_ready(front_ready),
      .up_data (front_data),
      .dn_valid(chroma_valid),
      .dn_ready(chroma_ready),
      .dn_data (chroma_data)
   );

   // divide and sector placement
   hsl2rgb_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .up_valid(chroma_valid),
      .up_ready(chroma_ready),
      .up_data (chroma_data),
      .dn_valid(rsp_valid),
      .dn_ready(rsp_ready),
      .dn_data (rsp_data)
   );

endmodule
